// ----- design/dual_gradient_pixel_energy_top_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef DUAL_GRADIENT_PIXEL_ENERGY_TOP_ASSERT_SVH
`define DUAL_GRADIENT_PIXEL_ENERGY_TOP_ASSERT_SVH

// Checked on every rising clock edge while the block is out of reset.
`define DGPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DGPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/dgpe_pkg.sv -----
package dgpe_pkg;

    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;
    localparam int ENERGY_W = 20;
    localparam int POS_W    = 11;
    localparam int SIZE_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int NUM_DIFF = 6;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_COLOR_MODE    = 2'd2,
        REG_MARGIN_ENERGY = 2'd3
    } cfg_reg_t;

    // Per-result control that travels with an item down the stages.
    typedef struct packed {
        logic             grad;
        logic             border;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } res_info_t;

endpackage

// ----- design/dual_gradient_pixel_energy_top.sv -----
// Dual-gradient pixel energy for seam carving over a raster-order pixel stream.
// Input channel: in_valid/in_ready carry one word per pixel (kind = pixel) with
// chan_a..chan_c, or a flush step (kind = flush). Output channel: out_valid/
// out_ready carry one energy word with its row, column, border and frame-end flags.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; it is
// always ready, and any write to a known register restarts the frame stream.
// Throughput is one word per clock on both channels while out_ready stays high.
// Each pixel reads both line buffers at its column in the cycle it is accepted;
// each buffer has a single read port and a registered read, and a write-back of
// the previous pixel to the same column is forwarded into the read register.
// A result moves through stage 1, stages 2 and 3 and the output register. In the
// stream, the result of a pixel is caused by the pixel one row and one column
// later; once the last pixel of the frame is in, the remaining row plus one
// results are drained by flush words, one result per flush word.
// When out_ready is low, results collect in the stage registers and in_ready
// falls only when every stage is full, so no word is lost or repeated.
// Reset clears the stage valid bits, counters and configuration (640 x 480,
// color, margin 1000). The line buffers are not cleared; entries not yet
// written only feed border results, which do not use them.
module dual_gradient_pixel_energy_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [dgpe_pkg::CHAN_W-1:0]      chan_a,
    input  logic [dgpe_pkg::CHAN_W-1:0]      chan_b,
    input  logic [dgpe_pkg::CHAN_W-1:0]      chan_c,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dgpe_pkg::ENERGY_W-1:0]    energy,
    output logic                             on_border,
    output logic [dgpe_pkg::POS_W-1:0]       out_row,
    output logic [dgpe_pkg::POS_W-1:0]       out_column,
    output logic                             frame_end,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dgpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dgpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Configuration registers.
    logic [dgpe_pkg::SIZE_W-1:0]   width_reg;
    logic [dgpe_pkg::SIZE_W-1:0]   height_reg;
    logic                          color_reg;
    logic [dgpe_pkg::ENERGY_W-1:0] margin_reg;

    // Stream position state.
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] nx_row_reg, nx_row_next;
    logic [CW-1:0] nx_col_reg, nx_col_next;
    logic          rcvd_reg, rcvd_next;

    // Line buffers and their read registers.
    logic [dgpe_pkg::PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
    logic [dgpe_pkg::PIXEL_W-1:0] middle_mem [MAX_WIDTH];
    logic [dgpe_pkg::PIXEL_W-1:0] up_rd_reg;
    logic [dgpe_pkg::PIXEL_W-1:0] mid_rd_reg;

    // The part of the 3x3 neighbourhood that later results still need.
    logic [dgpe_pkg::PIXEL_W-1:0] win_up_reg;
    logic [dgpe_pkg::PIXEL_W-1:0] win_mid_reg [2];
    logic [dgpe_pkg::PIXEL_W-1:0] win_px_reg;

    // Stage 1: memory read returned.
    logic                         s1_v_reg;
    logic                         s1_pix_reg;
    logic                         s1_emit_reg;
    logic [CW-1:0]                s1_addr_reg;
    logic [dgpe_pkg::PIXEL_W-1:0] s1_px_reg;
    dgpe_pkg::res_info_t          s1_info_reg;

    // Stage 2: absolute differences.
    logic                         s2_v_reg;
    logic [dgpe_pkg::CHAN_W-1:0]  s2_diff_reg [dgpe_pkg::NUM_DIFF];
    dgpe_pkg::res_info_t          s2_info_reg;

    // Stage 3: squares.
    logic                         s3_v_reg;
    logic [dgpe_pkg::SQ_W-1:0]    s3_sq_reg [dgpe_pkg::NUM_DIFF];
    dgpe_pkg::res_info_t          s3_info_reg;

    // Output register.
    logic                          o_v_reg;
    logic [dgpe_pkg::ENERGY_W-1:0] o_energy_reg;
    dgpe_pkg::res_info_t           o_info_reg;

    logic en_out, en3, en2, en1;
    logic take, do_pix, do_flush, do_emit, cfg_write, restart;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic [dgpe_pkg::PIXEL_W-1:0] px_in;
    logic          fwd;
    logic          s1_leave;
    dgpe_pkg::res_info_t info_new;
    logic [dgpe_pkg::CHAN_W-1:0] diff_new [dgpe_pkg::NUM_DIFF];
    logic [dgpe_pkg::ENERGY_W-1:0] sq_sum;

    function automatic logic [dgpe_pkg::CHAN_W-1:0] abs_diff(
        input logic [dgpe_pkg::CHAN_W-1:0] a,
        input logic [dgpe_pkg::CHAN_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Stage enables: a stage moves when it is empty or its successor moves.
    // A stage 1 word that causes no result leaves without a successor slot.
    assign en_out   = !o_v_reg || out_ready;
    assign en3      = !s3_v_reg || en_out;
    assign en2      = !s2_v_reg || en3;
    assign en1      = !s1_v_reg || !s1_emit_reg || en2;
    assign in_ready = en1;
    assign cfg_ready = 1'b1;

    assign take      = in_valid && in_ready;
    assign do_pix    = take && (kind == dgpe_pkg::KIND_PIXEL) && !rcvd_reg;
    assign do_flush  = take && (kind == dgpe_pkg::KIND_FLUSH) && rcvd_reg;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s1_leave  = s1_v_reg && en1;

    // Effective frame size less one: zero acts as one, oversize as the maximum.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_last = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(width_reg - 1'b1);
        end
        if (height_reg == '0)
        begin
            h_last = '0;
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_last = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = RW'(height_reg - 1'b1);
        end
    end

    // In grayscale only the first channel enters the line buffers.
    assign px_in = color_reg ? {chan_c, chan_b, chan_a}
                             : {{(2 * dgpe_pkg::CHAN_W){1'b0}}, chan_a};

    // Position bookkeeping, done entirely at acceptance.
    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        nx_row_next = nx_row_reg;
        nx_col_next = nx_col_reg;
        rcvd_next   = rcvd_reg;
        restart     = 1'b0;

        info_new.border = (nx_row_reg == '0) || (nx_col_reg == '0) ||
                          (nx_row_reg == h_last) || (nx_col_reg == w_last);
        info_new.last   = (nx_row_reg == h_last) && (nx_col_reg == w_last);
        info_new.grad   = do_pix && !info_new.border;
        info_new.row    = dgpe_pkg::POS_W'(nx_row_reg);
        info_new.col    = dgpe_pkg::POS_W'(nx_col_reg);

        // A pixel causes a result once a full row and one pixel are in.
        do_emit = do_flush ||
                  (do_pix && (((in_row_reg != '0) && (in_col_reg != '0)) ||
                              (in_row_reg[RW-1:1] != '0)));

        if (do_pix)
        begin
            if (in_col_reg == w_last)
            begin
                in_col_next = '0;
                if (in_row_reg == h_last)
                begin
                    rcvd_next = 1'b1;
                end
                else
                begin
                    in_row_next = RW'(in_row_reg + 1'b1);
                end
            end
            else
            begin
                in_col_next = CW'(in_col_reg + 1'b1);
            end
        end

        if (do_emit)
        begin
            if (info_new.last)
            begin
                restart = 1'b1;
            end
            else if (nx_col_reg == w_last)
            begin
                nx_col_next = '0;
                nx_row_next = RW'(nx_row_reg + 1'b1);
            end
            else
            begin
                nx_col_next = CW'(nx_col_reg + 1'b1);
            end
        end

        if (cfg_write && (cfg_index == dgpe_pkg::REG_FRAME_WIDTH ||
                          cfg_index == dgpe_pkg::REG_FRAME_HEIGHT ||
                          cfg_index == dgpe_pkg::REG_COLOR_MODE ||
                          cfg_index == dgpe_pkg::REG_MARGIN_ENERGY))
        begin
            restart = 1'b1;
        end

        if (restart)
        begin
            in_row_next = '0;
            in_col_next = '0;
            nx_row_next = '0;
            nx_col_next = '0;
            rcvd_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dgpe_pkg::SIZE_W'(640);
            height_reg <= dgpe_pkg::SIZE_W'(480);
            color_reg  <= 1'b1;
            margin_reg <= dgpe_pkg::ENERGY_W'(1000);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dgpe_pkg::REG_FRAME_WIDTH:   width_reg  <= cfg_data[dgpe_pkg::SIZE_W-1:0];
                dgpe_pkg::REG_FRAME_HEIGHT:  height_reg <= cfg_data[dgpe_pkg::SIZE_W-1:0];
                dgpe_pkg::REG_COLOR_MODE:    color_reg  <= cfg_data[0];
                dgpe_pkg::REG_MARGIN_ENERGY: margin_reg <= cfg_data;
                default:                     width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            nx_row_reg <= '0;
            nx_col_reg <= '0;
            rcvd_reg   <= 1'b0;
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            nx_row_reg <= nx_row_next;
            nx_col_reg <= nx_col_next;
            rcvd_reg   <= rcvd_next;
        end
    end

    // When the pixel leaving stage 1 writes the column that the new pixel
    // reads (one-column frames), its write data replaces the stale read.
    assign fwd = s1_v_reg && s1_pix_reg && (s1_addr_reg == in_col_reg);

    always_ff @(posedge clk)
    begin
        if (s1_leave && s1_pix_reg)
        begin
            upper_mem[s1_addr_reg]  <= mid_rd_reg;
            middle_mem[s1_addr_reg] <= s1_px_reg;
        end
        if (do_pix)
        begin
            up_rd_reg  <= fwd ? mid_rd_reg : upper_mem[in_col_reg];
            mid_rd_reg <= fwd ? s1_px_reg  : middle_mem[in_col_reg];
        end
    end

    // Differences against the neighbourhood as it stands after this pixel:
    // right is the fresh middle read, left the middle two columns back,
    // below the previous input pixel and above the previous upper read.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_new[2*k]   = abs_diff(mid_rd_reg[k*dgpe_pkg::CHAN_W +: dgpe_pkg::CHAN_W],
                                       win_mid_reg[0][k*dgpe_pkg::CHAN_W +: dgpe_pkg::CHAN_W]);
            diff_new[2*k+1] = abs_diff(win_px_reg[k*dgpe_pkg::CHAN_W +: dgpe_pkg::CHAN_W],
                                       win_up_reg[k*dgpe_pkg::CHAN_W +: dgpe_pkg::CHAN_W]);
            if (k != 0 && !color_reg)
            begin
                diff_new[2*k]   = '0;
                diff_new[2*k+1] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_up_reg     <= '0;
            win_mid_reg[0] <= '0;
            win_mid_reg[1] <= '0;
            win_px_reg     <= '0;
        end
        else if (s1_leave && s1_pix_reg)
        begin
            win_up_reg     <= up_rd_reg;
            win_mid_reg[0] <= win_mid_reg[1];
            win_mid_reg[1] <= mid_rd_reg;
            win_px_reg     <= s1_px_reg;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= do_pix || do_flush;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg && s1_emit_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (en_out)
            begin
                o_v_reg <= s3_v_reg;
            end
        end
    end

    always_comb
    begin
        sq_sum = '0;
        for (int k = 0; k < dgpe_pkg::NUM_DIFF; k++)
        begin
            sq_sum = sq_sum + dgpe_pkg::ENERGY_W'(s3_sq_reg[k]);
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en1 && (do_pix || do_flush))
        begin
            s1_pix_reg  <= do_pix;
            s1_emit_reg <= do_emit;
            s1_addr_reg <= in_col_reg;
            s1_px_reg   <= px_in;
            s1_info_reg <= info_new;
        end
        if (en2 && s1_v_reg && s1_emit_reg)
        begin
            s2_diff_reg <= diff_new;
            s2_info_reg <= s1_info_reg;
        end
        if (en3 && s2_v_reg)
        begin
            for (int k = 0; k < dgpe_pkg::NUM_DIFF; k++)
            begin
                s3_sq_reg[k] <= s2_diff_reg[k] * s2_diff_reg[k];
            end
            s3_info_reg <= s2_info_reg;
        end
        if (en_out && s3_v_reg)
        begin
            o_energy_reg <= s3_info_reg.grad ? sq_sum : margin_reg;
            o_info_reg   <= s3_info_reg;
        end
    end

    assign out_valid  = o_v_reg;
    assign energy     = o_energy_reg;
    assign on_border  = o_info_reg.border;
    assign out_row    = o_info_reg.row;
    assign out_column = o_info_reg.col;
    assign frame_end  = o_info_reg.last;

endmodule

// ----- design/dgpe_checker.sv -----
`include "dual_gradient_pixel_energy_top_assert.svh"

module dgpe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dgpe_pkg::ENERGY_W-1:0] energy,
    input logic                          on_border,
    input logic [dgpe_pkg::POS_W-1:0]    out_row,
    input logic [dgpe_pkg::POS_W-1:0]    out_column,
    input logic                          frame_end
);

    // A stalled result word holds until it is taken.
    `DGPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(energy) && $stable(out_row) && $stable(out_column), "stalled result word changed")

    // Interior results never sit in the first row or column.
    `DGPE_ASSERT(a_interior_pos, out_valid && !on_border |-> out_row != 0 && out_column != 0, "interior result on first row or column")

    // The last pixel of a frame is a corner, so it is always on the border.
    `DGPE_ASSERT(a_end_border, out_valid && frame_end |-> on_border, "frame end result not on border")

    // No result word is offered while reset is held.
    `DGPE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result word offered during reset")

endmodule

bind dual_gradient_pixel_energy_top dgpe_checker u_dgpe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .energy     (energy),
    .on_border  (on_border),
    .out_row    (out_row),
    .out_column (out_column),
    .frame_end  (frame_end)
);
